FILE: hdl/lgg_pkg.sv
`default_nettype none

package lgg_pkg;

   // Largest grid side the line buffers can hold, border included.
   localparam int MaxSide = 1024;
   localparam int AddrW   = $clog2(MaxSide);
   localparam int GridW   = 11;
   localparam int MinSide = 3;

   // Live neighborhood count (cell included) that gives a live cell; one more
   // also keeps a live cell alive.
   localparam int BirthCount = 3;

   typedef logic [AddrW-1:0] addr_type;

   // Per-cell tag worked out from the raster position when the beat is taken.
   typedef struct packed {
      logic emit;
      logic frame_end;
   } cell_tag_type;

   // Clamps a written grid size to the supported range and returns side - 1.
   function automatic addr_type side_last_of(input logic [GridW-1:0] grid_size);
      logic [31:0] side;
      side = 32'(grid_size);
      if (side < 32'(MinSide)) begin
         side = 32'(MinSide);
      end
      if (side > 32'(MaxSide)) begin
         side = 32'(MaxSide);
      end
      return AddrW'(side - 32'd1);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/lgg_line_buffer.sv
`default_nettype none

module lgg_line_buffer
   import lgg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     rd_en,
   input  wire addr_type rd_addr,
   output logic [1:0]    rd_data,
   input  wire logic     wr_en,
   input  wire addr_type wr_addr,
   input  wire logic [1:0] wr_data
);

   // Each word holds one column of the two rows above: bit 1 upper, bit 0 middle.
   logic [1:0] line_mem_ff [MaxSide];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/lgg_input_stage.sv
`default_nettype none

module lgg_input_stage
   import lgg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [GridW-1:0] csr_wr_data,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             cell_alive,
   input  wire logic             advance,
   output logic                  accept,
   output addr_type              rd_addr,
   output logic                  s1_valid,
   output logic                  s1_bot,
   output addr_type              s1_col,
   output cell_tag_type          s1_tag
);

   addr_type     side_last_ff, side_last_in;
   addr_type     col_ff, col_in;
   addr_type     row_ff, row_in;
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_bot_ff;
   addr_type     s1_col_ff;
   cell_tag_type s1_tag_ff, tag_now;

   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      tag_now.emit      = (row_ff >= AddrW'(2)) && (col_ff >= AddrW'(2));
      tag_now.frame_end = (row_ff == side_last_ff) && (col_ff == side_last_ff);
   end

   always_comb begin
      side_last_in = side_last_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (csr_wr_en) begin
         side_last_in = side_last_of(csr_wr_data);
         col_in       = '0;
         row_in       = '0;
      end else if (accept) begin
         if (col_ff == side_last_ff) begin
            col_in = '0;
            row_in = (row_ff == side_last_ff) ? '0 : row_ff + AddrW'(1);
         end else begin
            col_in = col_ff + AddrW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff <= side_last_of(GridW'(MaxSide));
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         side_last_ff <= side_last_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bot_ff <= cell_alive;
         s1_col_ff <= col_ff;
         s1_tag_ff <= tag_now;
      end
   end

   assign rd_addr  = col_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_bot   = s1_bot_ff;
   assign s1_col   = s1_col_ff;
   assign s1_tag   = s1_tag_ff;

   // The raster position never runs past the side in use.
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= side_last_ff) else $error("column past side");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= side_last_ff) else $error("row past side");

   // A held beat in the first stage is not overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |-> !accept) else $error("first stage overrun");

endmodule

`default_nettype wire

FILE: hdl/lgg_cell_update.sv
`default_nettype none

module lgg_cell_update
   import lgg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         restart,
   input  wire logic         s1_valid,
   input  wire logic         s1_bot,
   input  wire cell_tag_type s1_tag,
   input  wire logic [1:0]   above,
   output logic              advance,
   output logic [1:0]        wr_data,
   input  wire logic         rsp_tready,
   output logic              rsp_tvalid,
   output logic              next_alive,
   output logic              cell_changed,
   output logic              frame_last,
   output logic              frame_changed
);

   logic       out_free;
   logic       produce;
   logic [8:0] window_ff, window_in;
   logic [3:0] live_count;
   logic       me, next_now, chg_now;
   logic       any_change_ff, any_change_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       next_ff, chg_ff, last_ff, fchg_ff;

   function automatic logic [3:0] count_bits9(input logic [8:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 9; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = s1_valid && out_free;
   assign produce  = advance && s1_tag.emit;

   // New column enters at the low bits: upper, middle, then the incoming cell.
   assign window_in  = {window_ff[5:0], above[1], above[0], s1_bot};
   assign live_count = count_bits9(window_in);
   assign me         = window_in[4];
   assign next_now   = (live_count == 4'(BirthCount)) ||
                       (me && (live_count == 4'(BirthCount + 1)));
   assign chg_now    = next_now ^ me;

   // The middle row moves up and the incoming cell becomes the middle row.
   assign wr_data = {above[0], s1_bot};

   always_comb begin
      any_change_in = any_change_ff;
      if (restart) begin
         any_change_in = 1'b0;
      end else if (produce) begin
         any_change_in = s1_tag.frame_end ? 1'b0 : (any_change_ff | chg_now);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         any_change_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            window_ff <= window_in;
         end
         any_change_ff <= any_change_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         next_ff <= next_now;
         chg_ff  <= chg_now;
         last_ff <= s1_tag.frame_end;
         fchg_ff <= s1_tag.frame_end && (any_change_ff | chg_now);
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign next_alive    = next_ff;
   assign cell_changed  = chg_ff;
   assign frame_last    = last_ff;
   assign frame_changed = fchg_ff;

   a_fchg_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fchg_ff |-> last_ff) else $error("frame change off last");

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      produce && s1_tag.frame_end |=> !any_change_ff) else $error("change flag kept");

   a_change_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff && chg_ff |-> fchg_ff) else $error("change missed");

endmodule

`default_nettype wire

FILE: hdl/life_grid_generation_stream.sv
// One Game of Life generation (birth on 3, survival on 2 or 3) over a square
// grid streamed in raster order, one cell per beat on the req_ channel.
// The csr_ port sets the grid side, border included, clamped to 3..1024;
// a write also restarts the frame at row 0, column 0. Write it only while
// the block is idle.
// Once a beat arrives at row 2 or more and column 2 or more, the rsp_ channel
// carries the next state of the cell one row and one column behind, with its
// change bit. Border cells are used as neighbors but give no result beat.
// The beat for the last interior cell has tlast set and tuser telling whether
// any interior cell changed during the frame.
// An accepted req_ beat is registered in the first stage with its line buffer
// read; the 3x3 window update and rule then register its rsp_ beat.
// Throughput is one cell per cycle unless rsp_tready stalls, set by the line
// buffer memory taking one read and one write per cycle, on different columns.
// After reset the side is 1024 and the position is row 0, column 0; the line
// buffers are not cleared, since every interior result reads only entries
// written earlier in the same frame. When rsp_tready is low, one result is
// held and one more cell is taken into the first stage before req_tready drops.
`default_nettype none

module life_grid_generation_stream
   import lgg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [GridW-1:0] csr_wr_data,   // grid_size
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,     // [0] cell_alive, [7:1] zero
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,     // [0] next_alive, [1] cell_changed, [7:2] zero
   output logic                  rsp_tlast,     // frame_last
   output logic                  rsp_tuser      // frame_changed
);

   logic         accept;
   logic         advance;
   addr_type     rd_addr;
   logic [1:0]   above;
   logic [1:0]   wr_data;
   logic         s1_valid;
   logic         s1_bot;
   addr_type     s1_col;
   cell_tag_type s1_tag;
   logic         next_alive;
   logic         cell_changed;

   lgg_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .cell_alive  (req_tdata[0]),
      .advance     (advance),
      .accept      (accept),
      .rd_addr     (rd_addr),
      .s1_valid    (s1_valid),
      .s1_bot      (s1_bot),
      .s1_col      (s1_col),
      .s1_tag      (s1_tag)
   );

   lgg_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (above),
      .wr_en   (advance),
      .wr_addr (s1_col),
      .wr_data (wr_data)
   );

   lgg_cell_update u_cell_update (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_wr_en),
      .s1_valid      (s1_valid),
      .s1_bot        (s1_bot),
      .s1_tag        (s1_tag),
      .above         (above),
      .advance       (advance),
      .wr_data       (wr_data),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .next_alive    (next_alive),
      .cell_changed  (cell_changed),
      .frame_last    (rsp_tlast),
      .frame_changed (rsp_tuser)
   );

   assign rsp_tdata = {6'b0, cell_changed, next_alive};

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import lgg_pkg::*;

   localparam int unsigned SettleCycles = 8;
   localparam int unsigned LongHold    = 400;
   localparam int unsigned RandomCells = 360;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned HoldAfter   = 40;
   localparam longint unsigned TimeLimitNs = 10_000_000;

   typedef struct packed {
      logic next_alive;
      logic cell_changed;
      logic frame_last;
      logic frame_changed;
   } life_result_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             csr_wr_en      = 1'b0;
   logic [GridW-1:0] csr_wr_data    = '0;
   logic             req_tvalid     = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata      = '0;   // [0] cell_alive, [7:1] zero
   logic             rsp_tvalid;
   logic             rsp_tready     = 1'b1;
   logic [7:0]       rsp_tdata;             // [0] next_alive, [1] cell_changed, [7:2] zero
   logic             rsp_tlast;             // frame_last
   logic             rsp_tuser;             // frame_changed

   life_grid_generation_stream dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and scoreboard state.
   bit               cell_queue [$];
   life_result_type  next_gen_queue [$];
   int unsigned      cells_queued   = 0;
   int unsigned      cells_accepted = 0;
   int unsigned      results_seen   = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      send_gap       = 0;
   int unsigned      stall_left     = 0;
   bit               long_hold_done = 1'b0;
   bit               req_fire       = 1'b0;

   // Raster position of the stimulus, used to tell border cells apart; stim_side also sizes frames.
   int unsigned      stim_side = MaxSide;
   int unsigned      stim_row  = 0;
   int unsigned      stim_col  = 0;

   // Predictor state.
   bit               upper_row  [MaxSide];
   bit               middle_row [MaxSide];
   logic [8:0]       window_bits;
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic             changed_any;
   logic [GridW-1:0] grid_reg;

   function automatic int unsigned clamp_side(input logic [GridW-1:0] value);
      int unsigned s;
      s = 32'(value);
      if (s < MinSide) begin
         s = MinSide;
      end
      if (s > MaxSide) begin
         s = MaxSide;
      end
      return s;
   endfunction

   // Shifts one cell into the 3x3 window and predicts the interior cell behind it.
   task automatic step_life_cell(input logic alive);
      int unsigned     side;
      int unsigned     c;
      int unsigned     r;
      int unsigned     n;
      logic            me;
      logic            top;
      logic            mid;
      life_result_type res;
      side = clamp_side(grid_reg);
      c = (col_pos >= side) ? side - 1 : col_pos;
      r = (row_pos >= side) ? side - 1 : row_pos;
      top = upper_row[c];
      mid = middle_row[c];
      window_bits = {window_bits[5:0], top, mid, alive};
      upper_row[c] = mid;
      middle_row[c] = alive;
      if (r >= 2 && c >= 2) begin
         me = window_bits[4];
         n = $countones(window_bits);
         res.next_alive = (n == BirthCount) || (me && n == BirthCount + 1);
         res.cell_changed = res.next_alive ^ me;
         res.frame_last = (r == side - 1) && (c == side - 1);
         changed_any = changed_any | res.cell_changed;
         res.frame_changed = res.frame_last & changed_any;
         next_gen_queue.push_back(res);
      end
      if (c + 1 >= side) begin
         col_pos = 0;
         if (r + 1 >= side) begin
            row_pos = 0;
            changed_any = 1'b0;
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   // Monitor: mirrors register writes, predicts accepted cells, checks results.
   always @(posedge clock) begin
      life_result_type got;
      life_result_type want;
      req_fire = req_tvalid && req_tready && !reset;
      if (reset) begin
         window_bits = '0;
         col_pos = 0;
         row_pos = 0;
         changed_any = 1'b0;
         grid_reg = GridW'(MaxSide);
      end else begin
         if (csr_wr_en) begin
            grid_reg = csr_wr_data;
            col_pos = 0;
            row_pos = 0;
            changed_any = 1'b0;
         end
         if (req_fire) begin
            cells_accepted++;
            step_life_cell(req_tdata[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = '{rsp_tdata[0], rsp_tdata[1], rsp_tlast, rsp_tuser};
            if (next_gen_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports) begin
                  $display("result beat %0d arrived with none expected: got %b",
                           results_seen, got);
               end
            end else begin
               want = next_gen_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports) begin
                     $display("result beat %0d: expected %b got %b (next chg last fchg)",
                              results_seen, want, got);
                  end
               end
            end
         end
      end
   end

   // Driver: offers queued cells, with random gaps after a beat.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (cell_queue.size() != 0) begin
            req_tdata <= {7'd0, cell_queue.pop_front()};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(1, 16);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HoldAfter) begin
         long_hold_done = 1'b1;
         stall_left = LongHold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic offer_cell(input bit alive);
      cell_queue.push_back(alive);
      cells_queued++;
   endtask

   // Queues cells in raster order; density and rim_density are in sixteenths.
   task automatic queue_cells(input int unsigned count, input int unsigned density,
                              input int unsigned rim_density);
      int unsigned k;
      bit          on_border;
      for (k = 0; k < count; k++) begin
         on_border = stim_row == 0 || stim_row == stim_side - 1 ||
                     stim_col == 0 || stim_col == stim_side - 1;
         offer_cell($urandom_range(0, 15) < (on_border ? rim_density : density));
         if (stim_col + 1 >= stim_side) begin
            stim_col = 0;
            stim_row = (stim_row + 1 >= stim_side) ? 0 : stim_row + 1;
         end else begin
            stim_col++;
         end
      end
   endtask

   // One 3x3 frame, bit 0 first in raster order.
   task automatic queue_pattern(input logic [8:0] bits);
      int unsigned i;
      for (i = 0; i < 9; i++) begin
         offer_cell(bits[i]);
      end
   endtask

   // Waits until every cell is taken, every result checked and no gap or
   // stall is pending on either side.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (cells_accepted != cells_queued || next_gen_queue.size() != 0 ||
                 send_gap != 0 || stall_left != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_side(input logic [GridW-1:0] value);
      wait_idle();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      stim_side = clamp_side(value);
      stim_row = 0;
      stim_col = 0;
   endtask

   initial begin : stimulus
      int unsigned start_count;
      int unsigned pick;
      int unsigned side;
      int unsigned frames;
      int unsigned density;
      int unsigned f;
      send_idle_pct = 10;
      recv_stall_pct = 10;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // The side after reset is the largest one, so the first row gives no beat.
      queue_cells(24, 6, 0);

      // Sides below the minimum act as 3: survival on three neighbors,
      // birth from border cells, and death from overcrowding.
      write_side(GridW'(0));
      queue_pattern(9'h115);
      write_side(GridW'(1));
      queue_pattern(9'h045);
      write_side(GridW'(2));
      queue_pattern(9'h1FF);

      // The largest register value clamps to the largest side; the next write
      // then breaks off in the middle of the first row and restarts the frame.
      write_side('1);
      queue_cells(30, 6, 0);

      // Two full frames, during which the receiver holds off for a long stretch.
      write_side(GridW'(10));
      queue_cells(200, 6, 0);

      start_count = cells_queued;
      while (cells_queued - start_count < RandomCells) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            side = $urandom_range(3, 8);
         end else if (pick < 19) begin
            side = $urandom_range(9, 16);
         end else begin
            side = $urandom_range(17, 24);
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            write_side(GridW'($urandom_range(0, 2)));
         end else if (pick < 8) begin
            write_side(GridW'(side));
         end
         case ($urandom_range(0, 3))
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 15;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 15;
            end
            default: begin
               send_idle_pct = 20;
               recv_stall_pct = 20;
            end
         endcase
         pick = $urandom_range(0, 9);
         density = (pick == 0) ? 0 : (pick == 1) ? 16 : $urandom_range(2, 9);
         frames = (stim_side > 8) ? 1 : $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            queue_cells(stim_side * stim_side, density,
                        ($urandom_range(0, 4) == 0) ? density : 0);
         end
         // Now and then break off in mid-frame.
         if ($urandom_range(0, 3) == 0) begin
            queue_cells($urandom_range(1, stim_side * stim_side - 1), density, 0);
         end
      end

      // Closing stretch at full rate on both sides.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_side(GridW'(5));
      queue_cells(50, 6, 0);
      wait_idle();
      if (mismatch_count == 0 && next_gen_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TimeLimitNs);
      $display("Regression FAIL");
      $finish;
   end

endmodule
